### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Clocked assertion that also holds across reset.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

### rtl/fst_pkg.sv
// ----------------------------------------------------------------------------
// fst_pkg
// Types, widths and codes of the first-free slot table.
// ----------------------------------------------------------------------------
package fst_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam int OP_W        = 2;
   localparam int SLOT_IN_W   = 7;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int SLOT_OUT_W  = 6;
   localparam int COUNT_W     = 7;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_GET    = 2'd2;
   localparam logic [OP_W-1:0] OP_SET    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [SLOT_IN_W-1:0]  slot_index;
      logic [DATA_WIDTH-1:0] value;
      logic                  out_of_range;
   } fst_cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_RESP
   } fst_back_state_type;

endpackage

### rtl/fst_front.sv
// ----------------------------------------------------------------------------
// fst_front
// Accepts requests, flags out-of-range indexes and queues the commands.
// ----------------------------------------------------------------------------
module fst_front
   import fst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]        req_tuser,
   output logic                   cmd_valid,
   output fst_cmd_type            cmd,
   input  logic                   cmd_pop
);

   fst_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   fst_cmd_type new_cmd;
   logic        push;

   always_comb begin
      new_cmd.op           = req_tuser;
      new_cmd.slot_index   = req_tdata[SLOT_IN_W-1:0];
      new_cmd.value        = DATA_WIDTH'(req_tdata[SLOT_IN_W +: VALUE_W]);
      new_cmd.out_of_range = (req_tuser != OP_ADD) &&
                             (32'(req_tdata[SLOT_IN_W-1:0]) >= CAPACITY);
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### rtl/fst_back.sv
// ----------------------------------------------------------------------------
// fst_back
// Executes queued commands against the slot memory and occupancy bits,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module fst_back
   import fst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  fst_cmd_type            cmd,
   output logic                   cmd_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]    rsp_tuser
);

   fst_back_state_type state_ff, state_in;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic [CAPACITY-1:0]   occ_ff, occ_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  free_found_ff, free_found_in;
   logic [ADDR_W-1:0]     free_idx_ff, free_idx_in;

   logic [STATUS_W-1:0]   st_status_ff, st_status_in;
   logic [SLOT_OUT_W-1:0] st_slot_ff, st_slot_in;
   logic [VALUE_W-1:0]    st_vout_ff, st_vout_in;
   logic                  st_use_rd_ff, st_use_rd_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic                  rsp_load;
   logic [ADDR_W-1:0]     addr;
   logic                  hit;
   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     mem_waddr;

   // registered lowest-free-slot encoder
   always_comb begin
      free_found_in = ~&occ_ff;
      free_idx_in   = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!occ_ff[i]) begin
            free_idx_in = ADDR_W'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               state_in = BK_RESP;
            end
         end
         BK_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop  = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         BK_IDLE: cmd_pop  = cmd_valid;
         BK_RESP: rsp_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign addr = ADDR_W'(cmd.slot_index);
   assign hit  = occ_ff[addr];

   // execute
   always_comb begin
      occ_in       = occ_ff;
      count_in     = count_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = addr;
      st_status_in = ST_OK;
      st_slot_in   = SLOT_OUT_W'(cmd.slot_index);
      st_vout_in   = '0;
      st_use_rd_in = 1'b0;
      if (cmd_pop) begin
         priority if (cmd.op == OP_ADD) begin
            if (free_found_ff) begin
               mem_we              = 1'b1;
               mem_waddr           = free_idx_ff;
               occ_in[free_idx_ff] = (cmd.value != '0);
               st_slot_in          = SLOT_OUT_W'(free_idx_ff);
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end else begin
               st_status_in = ST_FULL;
               st_slot_in   = '0;
            end
         end else if (cmd.out_of_range) begin
            st_status_in = ST_RANGE;
         end else if (cmd.op == OP_REMOVE) begin
            if (hit) begin
               occ_in[addr] = 1'b0;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end else begin
               st_status_in = ST_EMPTY;
            end
         end else if (cmd.op == OP_GET) begin
            if (hit) begin
               mem_re       = 1'b1;
               st_use_rd_in = 1'b1;
            end else begin
               st_status_in = ST_EMPTY;
            end
         end else begin
            mem_we       = 1'b1;
            occ_in[addr] = (cmd.value != '0);
            st_vout_in   = VALUE_W'(cmd.value);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= cmd.value;
      end
      if (mem_re) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         occ_ff        <= '0;
         count_ff      <= '0;
         free_found_ff <= 1'b1;
         free_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         count_ff      <= count_in;
         free_found_ff <= free_found_in;
         free_idx_ff   <= free_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         st_status_ff <= st_status_in;
         st_slot_ff   <= st_slot_in;
         st_vout_ff   <= st_vout_in;
         st_use_rd_ff <= st_use_rd_in;
      end
      if (rsp_load) begin
         rsp_status_ff <= st_status_ff;
         rsp_slot_ff   <= st_slot_ff;
         rsp_value_ff  <= st_use_rd_ff ? VALUE_W'(rd_data_ff) : st_vout_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_count_ff, rsp_value_ff, rsp_slot_ff});

endmodule

### rtl/first_free_slot_table_core.sv
// ----------------------------------------------------------------------------
// first_free_slot_table_core
// Fixed table of handle slots with lowest-free-slot allocation.
// ----------------------------------------------------------------------------
// Requests enter on req_*: tuser carries the op (add, remove, get, set),
// tdata the slot index and the value. Each request gives one result on
// rsp_*: tuser carries the status, tdata the slot, the value and the used
// count after the request.
// The front end queues up to two commands; the back end executes one
// command at a time in two steps: the memory read or write and the
// occupancy update, then the load of the output register, which waits
// while the output register still holds a result that was not taken.
// Reset clears the occupancy bits and the used count, so every slot reads
// as free right away; no clearing pass is needed.
// When rsp_tready is low the result holds in the output register, the back
// end waits with the next result staged, and req_tready drops once the
// queue is full.
// ----------------------------------------------------------------------------
module first_free_slot_table_core
   import fst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // slot_index[6:0], value_in[38:7]
   input  logic [OP_W-1:0]        req_tuser,  // op[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // slot_out[5:0], value_out[37:6],
                                              // used_count[44:38]
   output logic [STATUS_W-1:0]    rsp_tuser   // status[1:0]
);

   logic        cmd_valid;
   logic        cmd_pop;
   fst_cmd_type cmd;

   fst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   fst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/fst_checker.sv
// ----------------------------------------------------------------------------
// fst_checker
// Port-level checks of the first-free slot table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fst_checker
   import fst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tready,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [STATUS_W-1:0]    rsp_tuser
);

   logic rsp_stall;
   logic rsp_full;
   logic rsp_no_value;

   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign rsp_full     = rsp_tvalid && (rsp_tuser == ST_FULL);
   assign rsp_no_value = rsp_tvalid && ((rsp_tuser == ST_RANGE) || (rsp_tuser == ST_EMPTY));

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_CLK(a_idle_after_reset, clock, $past(reset) && !reset |-> !rsp_tvalid && req_tready)
   `ASSERT_CLK_RST(a_full_fields, clock, reset, rsp_full |-> rsp_tdata[37:0] == 38'd0)
   `ASSERT_CLK_RST(a_error_no_value, clock, reset, rsp_no_value |-> rsp_tdata[37:6] == 32'd0)

endmodule

bind first_free_slot_table_core fst_checker u_fst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
